// ----- hdl/tbh_pkg.sv -----
package tbh_pkg;

  // Round count and golden-ratio step
  localparam int ROUNDS_DEFAULT = 16;
  localparam logic [31:0] GOLDEN_STEP = 32'h9e37_79b9;

  // Fixed key
  localparam logic [31:0] KEY_0 = 32'hA341_316C;
  localparam logic [31:0] KEY_1 = 32'hC801_3EA4;
  localparam logic [31:0] KEY_2 = 32'hAD90_777D;
  localparam logic [31:0] KEY_3 = 32'h7E95_761E;

  // Queue between front and round engine (power of two)
  localparam int QUEUE_DEPTH = 2;

  // Request as seen on the input port
  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_req;
  } tbh_in_req_t;

  // Classified request held in the queue
  typedef struct packed {
    logic [31:0] ext_word;
    logic        start;
  } tbh_entry_t;

  // Result request
  typedef struct packed {
    logic [31:0] hash_low;
    logic [31:0] hash_high;
  } tbh_result_t;

  // TEA half-round mixing term
  function automatic logic [31:0] tbh_mix(input logic [31:0] v, input logic [31:0] acc,
                                          input logic [31:0] k_lo, input logic [31:0] k_hi);
    return ((v << 4) + k_lo) ^ (v + acc) ^ ((v >> 5) + k_hi);
  endfunction

endpackage

// ----- hdl/tbh_stream_if.sv -----
interface tbh_stream_if #(parameter type payload_t = logic [7:0]) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ----- hdl/tbh_front.sv -----
module tbh_front (
  input logic         clk,
  input logic         rst_n,
  tbh_stream_if.sink   in_chan,
  tbh_stream_if.source q_chan
);
  import tbh_pkg::*;

  logic       fv_r, fv_nxt;
  tbh_entry_t entry_r;
  logic       take;

  // Front register frees whenever the queue takes its request
  assign in_chan.ready = !fv_r || q_chan.ready;
  assign take          = in_chan.valid && in_chan.ready;

  always_comb begin
    fv_nxt = fv_r;
    if (take) begin
      fv_nxt = 1'b1;
    end else if (q_chan.ready) begin
      fv_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else begin
      fv_r <= fv_nxt;
    end
  end

  // Sign-extend the byte as a signed char
  always_ff @(posedge clk) begin
    if (take) begin
      entry_r.ext_word <= {{24{in_chan.payload.data_byte[7]}}, in_chan.payload.data_byte};
      entry_r.start    <= in_chan.payload.start_req;
    end
  end

  assign q_chan.valid   = fv_r;
  assign q_chan.payload = entry_r;

endmodule

// ----- hdl/tbh_queue.sv -----
module tbh_queue (
  input logic         clk,
  input logic         rst_n,
  tbh_stream_if.sink   wr_chan,
  tbh_stream_if.source rd_chan
);
  import tbh_pkg::*;

  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  tbh_entry_t         entries_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]  count_r, count_nxt;
  logic               push, pop;

  assign wr_chan.ready   = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign rd_chan.valid   = (count_r != '0);
  assign rd_chan.payload = entries_r[rd_ptr_r];

  assign push = wr_chan.valid && wr_chan.ready;
  assign pop  = rd_chan.valid && rd_chan.ready;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= wr_chan.payload;
    end
  end

  // Fill count never passes the depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count exceeds depth");

  // A lone push grows the count by one
  a_push_grow: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> count_r == $past(count_r) + QCNT_W'(1))
    else $error("queue count did not grow on push");

  // Pointers stay in step with the fill count
  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    QPTR_W'(wr_ptr_r - rd_ptr_r) == QPTR_W'(count_r))
    else $error("queue pointers out of step with count");

endmodule

// ----- hdl/tbh_round_engine.sv -----
module tbh_round_engine #(
  parameter int ROUNDS = tbh_pkg::ROUNDS_DEFAULT
) (
  input logic         clk,
  input logic         rst_n,
  tbh_stream_if.sink   q_chan,
  tbh_stream_if.source out_chan
);
  import tbh_pkg::*;

  localparam int CNT_W = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;

  // Chain state (word_a, word_b) and round working registers
  logic [31:0]      a_r, a_nxt;
  logic [31:0]      b_r, b_nxt;
  logic [31:0]      acc_r, acc_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             half_r, half_nxt;
  logic             busy_r, busy_nxt;
  logic             out_valid_r, out_valid_nxt;
  tbh_result_t      result_r;

  logic [31:0] mix_v, mix_klo, mix_khi, mix, sum;
  logic        last, stall, take, advance;

  // One half-round per cycle if not stalled; first sets a, then b
  always_comb begin
    mix_v   = half_r ? a_r : b_r;
    mix_klo = half_r ? KEY_2 : KEY_0;
    mix_khi = half_r ? KEY_3 : KEY_1;
    mix     = tbh_mix(mix_v, acc_r, mix_klo, mix_khi);
    sum     = (half_r ? b_r : a_r) + mix;
  end

  assign last    = busy_r && half_r && (cnt_r == CNT_W'(ROUNDS - 1));
  assign stall   = last && out_valid_r && !out_chan.ready;
  assign advance = busy_r && !stall;
  assign take    = q_chan.valid && !busy_r;

  assign q_chan.ready = !busy_r;

  // Sequencer: load, iterate rounds, hand result to the output register
  always_comb begin
    a_nxt         = a_r;
    b_nxt         = b_r;
    acc_nxt       = acc_r;
    cnt_nxt       = cnt_r;
    half_nxt      = half_r;
    busy_nxt      = busy_r;
    out_valid_nxt = out_valid_r;

    if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    if (take) begin
      a_nxt    = (q_chan.payload.start ? 32'd0 : a_r) ^ q_chan.payload.ext_word;
      b_nxt    = q_chan.payload.start ? 32'd0 : b_r;
      acc_nxt  = GOLDEN_STEP;
      cnt_nxt  = '0;
      half_nxt = 1'b0;
      busy_nxt = 1'b1;
    end else if (advance) begin
      if (!half_r) begin
        a_nxt    = sum;
        half_nxt = 1'b1;
      end else begin
        b_nxt    = sum;
        half_nxt = 1'b0;
        acc_nxt  = acc_r + GOLDEN_STEP;
        cnt_nxt  = cnt_r + CNT_W'(1);
        if (last) begin
          busy_nxt      = 1'b0;
          out_valid_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r         <= '0;
      b_r         <= '0;
      busy_r      <= 1'b0;
      half_r      <= 1'b0;
      cnt_r       <= '0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      a_r         <= a_nxt;
      b_r         <= b_nxt;
      busy_r      <= busy_nxt;
      half_r      <= half_nxt;
      cnt_r       <= cnt_nxt;
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (last && !stall) begin
      result_r.hash_low  <= a_r;
      result_r.hash_high <= sum;
    end
  end

  assign out_chan.valid   = out_valid_r;
  assign out_chan.payload = result_r;

  // A taken request starts at the first half-round
  a_load_start: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> busy_r && !half_r && cnt_r == '0)
    else $error("round engine did not start after load");

  // Finishing the last round frees the engine and fills the output
  a_finish: assert property (@(posedge clk) disable iff (!rst_n)
    last && !stall |=> !busy_r && out_valid_r)
    else $error("round engine finish not delivered");

  // Engine never accepts while a hash is in flight
  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !q_chan.ready)
    else $error("queue popped while engine busy");

  // Round counter stays below the round count while busy
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> cnt_r <= CNT_W'(ROUNDS - 1))
    else $error("round counter overran");

endmodule

// ----- hdl/tea_byte_stream_hash_unit.sv -----
// Byte-stream hash on TEA rounds with a fixed key. Each byte (sign-extended as a signed
// char) is XORed into the low word, then ROUNDS TEA encryption rounds run over the
// word pair; start_req clears both words before its byte is absorbed, and every byte
// returns one result with both words. The input side takes a byte every cycle until a
// front register and a two-entry queue are full; the round engine computes one
// half-round per cycle through a single shared adder path, except while its last
// half-round waits on a full output register, and takes no new byte until the last
// round of the current one is done, so that engine sets the sustained rate. A finished
// result waits in an output register while the engine starts the next byte.
module tea_byte_stream_hash_unit #(
  parameter int ROUNDS = tbh_pkg::ROUNDS_DEFAULT
) (
  input logic         clk,
  input logic         rst_n,
  tbh_stream_if.sink   in_chan,
  tbh_stream_if.source out_chan
);
  import tbh_pkg::*;

  tbh_stream_if #(.payload_t(tbh_entry_t)) fq_chan ();
  tbh_stream_if #(.payload_t(tbh_entry_t)) qe_chan ();

  // Front: accept and classify
  tbh_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .q_chan  (fq_chan)
  );

  // Decoupling queue
  tbh_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_chan (fq_chan),
    .rd_chan (qe_chan)
  );

  // Back: TEA round engine and result register
  tbh_round_engine #(.ROUNDS(ROUNDS)) u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_chan   (qe_chan),
    .out_chan (out_chan)
  );

endmodule
